FILE: src/aqi_pkg.sv
package aqi_pkg;

	localparam int NUM_POLL = 5;
	localparam int TABLE_ROWS = 7;
	localparam int SEGMENTS = 7;
	localparam int ROWS_USED = (SEGMENTS < 1) ? 1 : ((SEGMENTS > TABLE_ROWS) ? TABLE_ROWS : SEGMENTS);
	localparam int ROW_W = $clog2(TABLE_ROWS);
	localparam int CONC_W = 16;
	localparam int MAG_W = 15;
	localparam int X_W = 22;
	localparam int RECIP_SHIFT = 22;
	localparam int RECIP_W = 16;
	localparam int SPAN_W = 13;
	localparam int Q_W = 16;
	localparam int SUB_W = 17;
	localparam int IDX_W = 12;
	localparam int CAT_W = 3;
	localparam logic [IDX_W-1:0] INDEX_MAX = '1;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);

	localparam logic [CAT_W-1:0] CAT_GOOD = 3'd0;
	localparam logic [CAT_W-1:0] CAT_MODERATE = 3'd1;
	localparam logic [CAT_W-1:0] CAT_SENSITIVE = 3'd2;
	localparam logic [CAT_W-1:0] CAT_UNHEALTHY = 3'd3;
	localparam logic [CAT_W-1:0] CAT_VERY_UNHEALTHY = 3'd4;
	localparam logic [CAT_W-1:0] CAT_HAZARDOUS = 3'd5;

	localparam logic [IDX_W-1:0] LIM_GOOD = 12'd50;
	localparam logic [IDX_W-1:0] LIM_MODERATE = 12'd100;
	localparam logic [IDX_W-1:0] LIM_SENSITIVE = 12'd150;
	localparam logic [IDX_W-1:0] LIM_UNHEALTHY = 12'd200;
	localparam logic [IDX_W-1:0] LIM_VERY_UNHEALTHY = 12'd300;

	localparam logic [MAG_W-1:0] CLO [NUM_POLL][TABLE_ROWS] = '{
		'{15'd0, 15'd90, 15'd354, 15'd554, 15'd1254, 15'd2254, 15'd3254},
		'{15'd0, 15'd540, 15'd1540, 15'd2540, 15'd3540, 15'd4240, 15'd5040},
		'{15'd0, 15'd530, 15'd1000, 15'd3600, 15'd6490, 15'd12490, 15'd16490},
		'{15'd0, 15'd350, 15'd750, 15'd1850, 15'd3040, 15'd6040, 15'd8040},
		'{15'd0, 15'd540, 15'd700, 15'd850, 15'd1050, 15'd2000, 15'd5040}
	};

	localparam logic [MAG_W-1:0] CHI [NUM_POLL][TABLE_ROWS] = '{
		'{15'd90, 15'd354, 15'd554, 15'd1254, 15'd2254, 15'd3254, 15'd5004},
		'{15'd540, 15'd1540, 15'd2540, 15'd3540, 15'd4240, 15'd5040, 15'd6040},
		'{15'd530, 15'd1000, 15'd3600, 15'd6490, 15'd12490, 15'd16490, 15'd20490},
		'{15'd350, 15'd750, 15'd1850, 15'd3040, 15'd6040, 15'd8040, 15'd10040},
		'{15'd540, 15'd700, 15'd850, 15'd1050, 15'd2000, 15'd5040, 15'd6040}
	};

	localparam logic [SPAN_W-1:0] SPAN [NUM_POLL][TABLE_ROWS] = '{
		'{13'd90, 13'd264, 13'd200, 13'd700, 13'd1000, 13'd1000, 13'd1750},
		'{13'd540, 13'd1000, 13'd1000, 13'd1000, 13'd700, 13'd800, 13'd1000},
		'{13'd530, 13'd470, 13'd2600, 13'd2890, 13'd6000, 13'd4000, 13'd4000},
		'{13'd350, 13'd400, 13'd1100, 13'd1190, 13'd3000, 13'd2000, 13'd2000},
		'{13'd540, 13'd160, 13'd150, 13'd200, 13'd950, 13'd3040, 13'd1000}
	};

	// Floor of 2**22 divided by the segment span.
	localparam logic [RECIP_W-1:0] RECIP [NUM_POLL][TABLE_ROWS] = '{
		'{16'd46603, 16'd15887, 16'd20971, 16'd5991, 16'd4194, 16'd4194, 16'd2396},
		'{16'd7767, 16'd4194, 16'd4194, 16'd4194, 16'd5991, 16'd5242, 16'd4194},
		'{16'd7913, 16'd8924, 16'd1613, 16'd1451, 16'd699, 16'd1048, 16'd1048},
		'{16'd11983, 16'd10485, 16'd3813, 16'd3524, 16'd1398, 16'd2097, 16'd2097},
		'{16'd7767, 16'd26214, 16'd27962, 16'd20971, 16'd4415, 16'd1379, 16'd4194}
	};

	localparam logic [6:0] DI [TABLE_ROWS] = '{7'd50, 7'd50, 7'd50, 7'd50, 7'd100, 7'd100, 7'd100};
	localparam logic [8:0] ILO [TABLE_ROWS] = '{9'd0, 9'd50, 9'd100, 9'd150, 9'd200, 9'd300, 9'd400};

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [MAG_W-1:0] diff;
	} lane_t;

	typedef lane_t [NUM_POLL-1:0] item_t;

	typedef logic signed [CONC_W-1:0] conc_t;

endpackage

FILE: src/aqi_front.sv
module aqi_front import aqi_pkg::*; (
	input conc_t conc [NUM_POLL],
	output item_t item
);

	always_comb begin
		for (int p = 0; p < NUM_POLL; p++) begin
			logic [ROW_W-1:0] r;
			logic [MAG_W-1:0] v;
			v = conc[p][MAG_W-1:0];
			r = ROW_W'(ROWS_USED - 1);
			for (int i = ROWS_USED - 1; i >= 0; i--) begin
				if (v <= CHI[p][i]) begin
					r = ROW_W'(i);
				end
			end
			if (conc[p][CONC_W-1]) begin
				item[p].row = '0;
				item[p].diff = '0;
			end else begin
				item[p].row = r;
				item[p].diff = v - CLO[p][r];
			end
		end
	end

endmodule

FILE: src/aqi_fifo.sv
module aqi_fifo import aqi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input item_t wr_data,
	output logic full,
	input logic rd_en,
	output logic nonempty,
	output item_t rd_data
);

	item_t mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0] count_q;

	assign full = (count_q == (PTR_W+1)'(FIFO_DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/aqi_back.sv
module aqi_back import aqi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_avail,
	input item_t in_item,
	output logic in_take,
	output logic empty,
	input logic pop,
	output logic [IDX_W-1:0] overall_index,
	output logic [CAT_W-1:0] category
);

	logic adv;
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic [X_W-1:0] x_s1 [NUM_POLL];
	logic [X_W-1:0] x_s2 [NUM_POLL];
	logic [ROW_W-1:0] row_s1 [NUM_POLL];
	logic [ROW_W-1:0] row_s2 [NUM_POLL];
	logic [Q_W-1:0] qe_s2 [NUM_POLL];
	logic [SUB_W-1:0] sub_s3 [NUM_POLL];
	logic [IDX_W-1:0] best_idx;
	logic [CAT_W-1:0] best_cat;

	assign adv = !out_valid_q || pop;
	assign in_take = adv && in_avail;
	assign empty = !out_valid_q;

	always_comb begin
		logic [SUB_W-1:0] best;
		best = '0;
		for (int p = 0; p < NUM_POLL; p++) begin
			if (sub_s3[p] > best) begin
				best = sub_s3[p];
			end
		end
		if (best > SUB_W'(INDEX_MAX)) begin
			best_idx = INDEX_MAX;
		end else begin
			best_idx = best[IDX_W-1:0];
		end
		if (best_idx <= LIM_GOOD) begin
			best_cat = CAT_GOOD;
		end else if (best_idx <= LIM_MODERATE) begin
			best_cat = CAT_MODERATE;
		end else if (best_idx <= LIM_SENSITIVE) begin
			best_cat = CAT_SENSITIVE;
		end else if (best_idx <= LIM_UNHEALTHY) begin
			best_cat = CAT_UNHEALTHY;
		end else if (best_idx <= LIM_VERY_UNHEALTHY) begin
			best_cat = CAT_VERY_UNHEALTHY;
		end else begin
			best_cat = CAT_HAZARDOUS;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int p = 0; p < NUM_POLL; p++) begin
				logic [37:0] prod;
				logic [28:0] back;
				logic [28:0] rem;
				logic [Q_W-1:0] q;
				x_s1[p] <= X_W'(DI[in_item[p].row]) * X_W'(in_item[p].diff)
					+ X_W'(SPAN[p][in_item[p].row] >> 1);
				row_s1[p] <= in_item[p].row;

				prod = 38'(x_s1[p]) * 38'(RECIP[p][row_s1[p]]);
				qe_s2[p] <= prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
				x_s2[p] <= x_s1[p];
				row_s2[p] <= row_s1[p];

				back = 29'(qe_s2[p]) * 29'(SPAN[p][row_s2[p]]);
				rem = 29'(x_s2[p]) - back;
				q = qe_s2[p] + Q_W'(rem >= 29'(SPAN[p][row_s2[p]]));
				sub_s3[p] <= SUB_W'(q) + SUB_W'(ILO[row_s2[p]]);
			end
			overall_index <= best_idx;
			category <= best_cat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_avail;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

endmodule

FILE: src/air_quality_index_calc_core.sv
// Channel  | Direction | Handshake   | Fields
// request  | in        | push / full | pm25_tenths, pm10_tenths, no2_tenths, so2_tenths, o3_tenths
// result   | out       | empty / pop | overall_index, category
//
// One request is taken every cycle while the queue is not full; its result reaches the result
// ports through the four-entry queue, then the three arithmetic stages of the back end ahead
// of the output register.
// Reset clears the queue and all valid flags; the block is ready in the first cycle after it.
// A held result stalls the whole back end, while the front keeps filling the queue until full.
module air_quality_index_calc_core import aqi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic signed [15:0] pm25_tenths,
	input logic signed [15:0] pm10_tenths,
	input logic signed [15:0] no2_tenths,
	input logic signed [15:0] so2_tenths,
	input logic signed [15:0] o3_tenths,
	output logic empty,
	input logic pop,
	output logic [11:0] overall_index,
	output logic [2:0] category
);

	conc_t conc [NUM_POLL];
	item_t front_item;
	item_t queue_item;
	logic queue_avail;
	logic queue_take;

	assign conc[0] = pm25_tenths;
	assign conc[1] = pm10_tenths;
	assign conc[2] = no2_tenths;
	assign conc[3] = so2_tenths;
	assign conc[4] = o3_tenths;

	aqi_front u_front (
		.conc(conc),
		.item(front_item)
	);

	aqi_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(push && !full),
		.wr_data(front_item),
		.full(full),
		.rd_en(queue_take),
		.nonempty(queue_avail),
		.rd_data(queue_item)
	);

	aqi_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_avail(queue_avail),
		.in_item(queue_item),
		.in_take(queue_take),
		.empty(empty),
		.pop(pop),
		.overall_index(overall_index),
		.category(category)
	);

endmodule

FILE: src/aqi_checker.sv
module aqi_checker import aqi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic [11:0] overall_index,
	input logic [2:0] category
);

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (category <= CAT_HAZARDOUS))
		else $error("category code out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((category == CAT_GOOD) == (overall_index <= LIM_GOOD))
			&& ((category == CAT_HAZARDOUS) == (overall_index > LIM_VERY_UNHEALTHY)))
		else $error("category does not match overall index");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(overall_index) && $stable(category)))
		else $error("stalled result changed");

endmodule

bind air_quality_index_calc_core aqi_checker u_aqi_checker (.*);

FILE: tb/sv/aqi_result_checker.sv
`timescale 1ns / 100ps
module aqi_result_checker import aqi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic signed [15:0] pm25_tenths,
	input logic signed [15:0] pm10_tenths,
	input logic signed [15:0] no2_tenths,
	input logic signed [15:0] so2_tenths,
	input logic signed [15:0] o3_tenths,
	input logic empty,
	input logic pop,
	input logic [11:0] overall_index,
	input logic [2:0] category,
	output int fail_count,
	output int pending,
	output int results_seen
);
	typedef struct {
		logic [IDX_W-1:0] idx;
		logic [CAT_W-1:0] cat;
	} aqi_pred_t;

	aqi_pred_t expected_aqi[$];

	function automatic int unsigned lane_index(logic [15:0] raw, int p);
		int unsigned v;
		int unsigned lo;
		int unsigned hi;
		int unsigned span;
		int unsigned dv;
		int unsigned base;
		int r;
		int hit;
		if (raw[15])
			return 0;
		v = 32'(raw[14:0]);
		hit = ROWS_USED - 1;
		for (r = ROWS_USED - 1; r >= 0; r--) begin
			lo = 32'(CLO[p][r]);
			hi = 32'(CHI[p][r]);
			if (v >= lo && v <= hi)
				hit = r;
		end
		lo = 32'(CLO[p][hit]);
		span = 32'(CHI[p][hit]) - lo;
		base = (hit < 4) ? 50 * hit : 200 + 100 * (hit - 4);
		dv = (hit < 4) ? 50 : 100;
		if (v < lo)
			return 0;
		if (span == 0)
			return base;
		return (dv * (v - lo) + span / 2) / span + base;
	endfunction

	function automatic aqi_pred_t predict_aqi(logic [15:0] a, logic [15:0] b, logic [15:0] c,
			logic [15:0] d, logic [15:0] e);
		aqi_pred_t res;
		int unsigned best;
		int unsigned s;
		best = 0;
		s = lane_index(a, 0); if (s > best) best = s;
		s = lane_index(b, 1); if (s > best) best = s;
		s = lane_index(c, 2); if (s > best) best = s;
		s = lane_index(d, 3); if (s > best) best = s;
		s = lane_index(e, 4); if (s > best) best = s;
		if (best > 4095)
			best = 4095;
		res.idx = IDX_W'(best);
		if (best <= 50) res.cat = CAT_GOOD;
		else if (best <= 100) res.cat = CAT_MODERATE;
		else if (best <= 150) res.cat = CAT_SENSITIVE;
		else if (best <= 200) res.cat = CAT_UNHEALTHY;
		else if (best <= 300) res.cat = CAT_VERY_UNHEALTHY;
		else res.cat = CAT_HAZARDOUS;
		return res;
	endfunction

	assign pending = expected_aqi.size();

	always @(posedge clk or negedge arst_n) begin
		aqi_pred_t want;
		if (!arst_n) begin
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			if (push && !full)
				expected_aqi.push_back(predict_aqi(pm25_tenths, pm10_tenths, no2_tenths,
						so2_tenths, o3_tenths));
			if (pop && !empty) begin
				results_seen <= results_seen + 1;
				if (expected_aqi.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result idx=%0d cat=%0d", overall_index, category);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_aqi.pop_front();
					if (want.idx !== overall_index || want.cat !== category) begin
						if (fail_count < 10)
							$display("mismatch: expected idx=%0d cat=%0d, got idx=%0d cat=%0d",
									want.idx, want.cat, overall_index, category);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

FILE: tb/sv/tb_air_quality_index_calc_core.sv
`timescale 1ns / 100ps
module tb_air_quality_index_calc_core import aqi_pkg::*;;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	logic signed [15:0] pm25_tenths = '0;
	logic signed [15:0] pm10_tenths = '0;
	logic signed [15:0] no2_tenths = '0;
	logic signed [15:0] so2_tenths = '0;
	logic signed [15:0] o3_tenths = '0;
	logic [11:0] overall_index;
	logic [2:0] category;
	int fail_count;
	int pending;
	int results_seen;
	int idle_cycles = 0;
	int requests_sent = 0;
	bit stimulus_done = 1'b0;
	bit hold_reads = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	air_quality_index_calc_core dut (.*);

	aqi_result_checker checker_inst (.*);

	task automatic send_request(logic [15:0] a, logic [15:0] b, logic [15:0] c,
			logic [15:0] d, logic [15:0] e);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		pm25_tenths <= a;
		pm10_tenths <= b;
		no2_tenths <= c;
		so2_tenths <= d;
		o3_tenths <= e;
		@(posedge clk);
		while (full)
			@(posedge clk);
		requests_sent++;
	endtask

	function automatic logic [15:0] random_conc(int p);
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'(-$urandom_range(1, 50));
			2: return 16'($urandom_range(0, 200));
			3: return 16'(CLO[p][$urandom_range(0, TABLE_ROWS - 1)]
					+ $urandom_range(0, 2) - 1);
			4: return 16'(CHI[p][$urandom_range(0, TABLE_ROWS - 1)]
					+ $urandom_range(0, 2) - 1);
			5: return 16'($urandom_range(CHI[p][TABLE_ROWS - 1], 32767));
			default: return 16'($urandom_range(0, CHI[p][TABLE_ROWS - 1]));
		endcase
	endfunction

	initial begin
		logic [15:0] v;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_request(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
		for (int p = 0; p < NUM_POLL; p++)
			for (int r = 0; r < TABLE_ROWS; r += 2) begin
				v = CHI[p][r];
				send_request(p == 0 ? v : 16'd0, p == 1 ? v : 16'd0, p == 2 ? v : 16'd0,
						p == 3 ? v : 16'd0, p == 4 ? v : 16'd0);
			end
		send_request(16'd5005, 16'd6041, 16'd20491, 16'd10041, 16'd6041);
		for (int k = 0; k < 530; k++) begin
			if (k == 200)
				hold_reads = 1'b1;
			if (k == 230)
				hold_reads = 1'b0;
			send_request(random_conc(0), random_conc(1), random_conc(2), random_conc(3),
					random_conc(4));
		end
		push <= 1'b0;
		stimulus_done = 1'b1;
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_reads)
				gap = 40;
			else
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("air_quality_index_calc_core verification failed");
			$finish;
		end
	end

	initial begin
		wait (stimulus_done);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		$display("Sent %0d requests and checked %0d results, including a long read stall.",
				requests_sent, results_seen);
		if (fail_count == 0 && pending == 0)
			$display("air_quality_index_calc_core verification clean");
		else
			$display("air_quality_index_calc_core verification failed");
		$finish;
	end
endmodule
